FILE: design/handheld_bus_address_decoder_defines.svh
// Assertion macros shared by the bus decoder checker.
`ifndef HANDHELD_BUS_ADDRESS_DECODER_DEFINES_SVH
`define HANDHELD_BUS_ADDRESS_DECODER_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define HBAD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HBAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hbad_pkg.sv
// Package for the bus address decoder: codes, result type and table helper.
`default_nettype none

package hbad_pkg;

    localparam int VRAM_BYTES_DEF  = 98304;
    localparam int FLASH_BYTES_DEF = 131072;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 2;
    localparam int DATA_W   = 32;
    localparam int OFFSET_W = 25;
    localparam int ROMSZ_W  = 16;
    localparam int TARGET_W = 4;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 96;

    typedef enum logic [SIZE_W-1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2,
        SIZE_BAD  = 2'd3
    } access_size_t;

    typedef enum logic [TARGET_W-1:0] {
        TGT_BIOS  = 4'd0,
        TGT_EWRAM = 4'd1,
        TGT_IWRAM = 4'd2,
        TGT_IO    = 4'd3,
        TGT_PAL   = 4'd4,
        TGT_VRAM  = 4'd5,
        TGT_OAM   = 4'd6,
        TGT_ROM   = 4'd7,
        TGT_FLASH = 4'd8,
        TGT_FAULT = 4'd9
    } target_t;

    typedef struct packed {
        target_t               target;
        logic [OFFSET_W-1:0]   offset;
        logic [DATA_W-1:0]     data;
        logic [ADDR_W-1:0]     fault_address;
    } dec_result_t;

    // (count * step) mod m by repeated add and subtract; needs step <= m.
    function automatic int mod_mult(input int m, input int step, input int count);
        int r;
        r = 0;
        for (int i = 0; i < count; i++)
        begin
            r = r + step;
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/hbad_decode.sv
// Combinational decode of one aligned bus access into target store and offset.
`default_nettype none

module hbad_decode #(
    parameter int VRAM_BYTES  = hbad_pkg::VRAM_BYTES_DEF,
    parameter int FLASH_BYTES = hbad_pkg::FLASH_BYTES_DEF
) (
    input  wire logic [hbad_pkg::ADDR_W-1:0]  address,
    input  wire logic [hbad_pkg::SIZE_W-1:0]  access_size,
    input  wire logic                         is_write,
    input  wire logic [hbad_pkg::DATA_W-1:0]  write_data,
    input  wire logic [hbad_pkg::ROMSZ_W-1:0] rom_size_blocks,
    output hbad_pkg::dec_result_t             result
);

    localparam int VRAM_W  = $clog2(VRAM_BYTES);
    localparam int VSUM_W  = VRAM_W + 2;
    localparam int STEP_HI = hbad_pkg::mod_mult(VRAM_BYTES, 1024, 128);
    localparam logic [VSUM_W-1:0] VRAM_M1 = VSUM_W'(VRAM_BYTES);
    localparam logic [VSUM_W-1:0] VRAM_M2 = VSUM_W'(2 * VRAM_BYTES);
    localparam logic [hbad_pkg::OFFSET_W-1:0] FLASH_START =
        hbad_pkg::OFFSET_W'(32'h0200_0000 - FLASH_BYTES);

    // (k * 2^10) mod M and (k * 2^17) mod M for the two upper 7-bit chunks
    logic [VRAM_W-1:0] tab_mid [128];
    logic [VRAM_W-1:0] tab_hi  [128];

    for (genvar g = 0; g < 128; g++)
    begin : g_tab
        assign tab_mid[g] = VRAM_W'(hbad_pkg::mod_mult(VRAM_BYTES, 1024, g));
        assign tab_hi[g]  = VRAM_W'(hbad_pkg::mod_mult(VRAM_BYTES, STEP_HI, g));
    end

    logic [hbad_pkg::ADDR_W-1:0]   a;
    logic [3:0]                    region;
    logic                          in_map;
    logic [VSUM_W-1:0]             vsum;
    logic [VSUM_W-1:0]             vmod;
    logic [hbad_pkg::OFFSET_W-1:0] rel;
    hbad_pkg::target_t             tgt;
    logic [hbad_pkg::OFFSET_W-1:0] off;

    always_comb
    begin
        case (access_size)
            hbad_pkg::SIZE_BYTE: a = address;
            hbad_pkg::SIZE_HALF: a = {address[31:1], 1'b0};
            default:             a = {address[31:2], 2'b00};
        endcase
    end

    assign region = a[27:24];
    assign in_map = (a[31:28] == 4'h0);
    assign rel    = a[24:0];

    // low 10 bits are below M, so the sum stays under 3M
    assign vsum = VSUM_W'(a[9:0]) + VSUM_W'(tab_mid[a[16:10]]) + VSUM_W'(tab_hi[a[23:17]]);

    always_comb
    begin
        if (vsum >= VRAM_M2)
        begin
            vmod = vsum - VRAM_M2;
        end
        else if (vsum >= VRAM_M1)
        begin
            vmod = vsum - VRAM_M1;
        end
        else
        begin
            vmod = vsum;
        end
    end

    always_comb
    begin
        tgt = hbad_pkg::TGT_FAULT;
        off = '0;
        if (access_size != hbad_pkg::SIZE_BAD && in_map)
        begin
            case (region)
                4'h0, 4'h1:
                begin
                    if (a[27:14] == '0 && !is_write)
                    begin
                        tgt = hbad_pkg::TGT_BIOS;
                        off = {11'd0, a[13:0]};
                    end
                end
                4'h2:
                begin
                    tgt = hbad_pkg::TGT_EWRAM;
                    off = {7'd0, a[17:0]};
                end
                4'h3:
                begin
                    tgt = hbad_pkg::TGT_IWRAM;
                    off = {10'd0, a[14:0]};
                end
                4'h4:
                begin
                    tgt = hbad_pkg::TGT_IO;
                    off = {9'd0, a[15:0]};
                end
                4'h5:
                begin
                    tgt = hbad_pkg::TGT_PAL;
                    off = {15'd0, a[9:0]};
                end
                4'h6:
                begin
                    tgt = hbad_pkg::TGT_VRAM;
                    off = hbad_pkg::OFFSET_W'(vmod[VRAM_W-1:0]);
                end
                4'h7:
                begin
                    tgt = hbad_pkg::TGT_OAM;
                    off = {15'd0, a[9:0]};
                end
                default:
                begin
                    if (region inside {[4'h8:4'hD]})
                    begin
                        // flash sits over the top of every window and wins
                        if (rel >= FLASH_START)
                        begin
                            tgt = hbad_pkg::TGT_FLASH;
                            off = rel - FLASH_START;
                        end
                        else if ({1'b0, rel[24:10]} < rom_size_blocks && !is_write)
                        begin
                            tgt = hbad_pkg::TGT_ROM;
                            off = rel;
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        result.target        = tgt;
        result.offset        = off;
        result.data          = '0;
        result.fault_address = '0;
        if (tgt == hbad_pkg::TGT_FAULT)
        begin
            result.offset        = '0;
            result.fault_address = a;
        end
        else if (is_write)
        begin
            result.data = write_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/handheld_bus_address_decoder.sv
// Top level of the bus address decoder: stream handshake, config register, pipeline.
//
//  channel | dir | handshake               | contents
//  s_axis  | in  | s_axis_tvalid/tready    | one bus access
//  m_axis  | out | m_axis_tvalid/tready    | decoded target, offset, pass-through
//  cfg     | in  | cfg_we (no back-pressure)| rom_size_blocks
//
// Result path: input register, combinational decode, result register.
// One item per cycle unless m_axis stalls; decode is a single table-and-compare pass.
// rst_n clears the valid flags and rom_size_blocks at once; no clearing pass.
// A stalled result holds; new items are still taken while the input stage is free.
`default_nettype none

module handheld_bus_address_decoder #(
    parameter int VRAM_BYTES  = hbad_pkg::VRAM_BYTES_DEF,
    parameter int FLASH_BYTES = hbad_pkg::FLASH_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hbad_pkg::ROMSZ_W-1:0]    cfg_wdata,     // rom_size_blocks
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // address[31:0], access_size[33:32], is_write[34], write_data[66:35], zero fill
    input  wire logic [hbad_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // store_offset[24:0], size_out[26:25], write_out[27], data_out[59:28],
    // fault_address[91:60], zero fill
    output logic [hbad_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic [hbad_pkg::TARGET_W-1:0]        m_axis_tuser    // target[3:0]
);

    logic [hbad_pkg::ROMSZ_W-1:0] rom_size_reg;

    logic                         in_valid_reg;
    logic [hbad_pkg::ADDR_W-1:0]  in_addr_reg;
    logic [hbad_pkg::SIZE_W-1:0]  in_size_reg;
    logic                         in_write_reg;
    logic [hbad_pkg::DATA_W-1:0]  in_data_reg;

    logic                         out_valid_reg;
    hbad_pkg::dec_result_t        out_res_reg;
    logic [hbad_pkg::SIZE_W-1:0]  out_size_reg;
    logic                         out_write_reg;

    hbad_pkg::dec_result_t        dec_res;
    logic                         out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            rom_size_reg <= cfg_wdata;
        end
    end

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_addr_reg  <= s_axis_tdata[31:0];
            in_size_reg  <= s_axis_tdata[33:32];
            in_write_reg <= s_axis_tdata[34];
            in_data_reg  <= s_axis_tdata[66:35];
        end
    end

    hbad_decode #(
        .VRAM_BYTES  (VRAM_BYTES),
        .FLASH_BYTES (FLASH_BYTES)
    ) u_decode (
        .address         (in_addr_reg),
        .access_size     (in_size_reg),
        .is_write        (in_write_reg),
        .write_data      (in_data_reg),
        .rom_size_blocks (rom_size_reg),
        .result          (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && in_valid_reg)
        begin
            out_res_reg   <= dec_res;
            out_size_reg  <= in_size_reg;
            out_write_reg <= in_write_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.target;
    assign m_axis_tdata  = {4'd0, out_res_reg.fault_address, out_res_reg.data,
                            out_write_reg, out_size_reg, out_res_reg.offset};

endmodule

`default_nettype wire

FILE: design/hbad_checker.sv
// Port-level checks for the bus address decoder, bound to the top level.
`default_nettype none
`include "handheld_bus_address_decoder_defines.svh"

module hbad_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic [hbad_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input wire logic [hbad_pkg::TARGET_W-1:0]   m_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready
);

    logic [hbad_pkg::M_TDATA_W+hbad_pkg::TARGET_W:0] res_all;
    logic [56:0]                                     res_payload;
    logic [hbad_pkg::ADDR_W-1:0]                     res_faddr;
    logic                                            res_stall;
    logic                                            res_is_fault;
    logic                                            res_fault;
    logic                                            res_mapped;
    logic                                            res_bad_size;
    logic                                            res_write;
    logic                                            res_ro_target;

    assign res_all       = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};
    // offset and data, skipping size and direction
    assign res_payload   = {m_axis_tdata[59:28], m_axis_tdata[24:0]};
    assign res_faddr     = m_axis_tdata[91:60];
    assign res_stall     = m_axis_tvalid && !m_axis_tready;
    assign res_is_fault  = (m_axis_tuser == hbad_pkg::TGT_FAULT);
    assign res_fault     = m_axis_tvalid && res_is_fault;
    assign res_mapped    = m_axis_tvalid && !res_is_fault;
    assign res_bad_size  = m_axis_tvalid && (m_axis_tdata[26:25] == hbad_pkg::SIZE_BAD);
    assign res_write     = m_axis_tvalid && m_axis_tdata[27];
    assign res_ro_target = (m_axis_tuser == hbad_pkg::TGT_ROM)
                           || (m_axis_tuser == hbad_pkg::TGT_BIOS);

    `HBAD_ASSERT_NEXT(a_out_hold, res_stall, $stable(res_all), "stalled result changed")

    `HBAD_ASSERT_IMPL(a_fault_zero, res_fault, res_payload == '0, "fault with payload")

    `HBAD_ASSERT_IMPL(a_ok_no_faddr, res_mapped, res_faddr == '0, "stray fault address")

    `HBAD_ASSERT_IMPL(a_bad_size_faults, res_bad_size, res_is_fault, "size three did not fault")

    `HBAD_ASSERT_IMPL(a_ro_write, res_write, !res_ro_target, "write reached a read-only store")

endmodule

bind handheld_bus_address_decoder hbad_checker u_hbad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
